FILE: hdl/scba_pkg.sv
// ----------------------------------------------------------------------------
// scba_pkg
// Shared types, widths and codes of the size-class buffer allocator.
// ----------------------------------------------------------------------------
package scba_pkg;

  // Number of size classes and blocks per class.
  localparam int NumClasses = 4;
  localparam int MaxBlocks  = 1024;

  // Field widths.
  localparam int ClsW   = $clog2(NumClasses);
  localparam int IdxW   = $clog2(MaxBlocks);
  localparam int CntW   = IdxW + 1;
  localparam int AddrW  = ClsW + IdxW;
  localparam int LenW   = 32;
  localparam int StW    = 2;
  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 32;

  // Stream payload widths, padded to whole bytes.
  localparam int InDataW  = 48;
  localparam int OutDataW = 16;

  // Result status codes.
  localparam logic [StW-1:0] StOk      = 2'd0;
  localparam logic [StW-1:0] StFail    = 2'd1;
  localparam logic [StW-1:0] StIgnored = 2'd2;

  // Action codes carried in the input tuser.
  localparam logic ActAlloc = 1'b0;
  localparam logic ActFree  = 1'b1;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] RegClass0Bytes = 3'd0;
  localparam logic [CfgIdxW-1:0] RegClass1Bytes = 3'd1;
  localparam logic [CfgIdxW-1:0] RegClass2Bytes = 3'd2;
  localparam logic [CfgIdxW-1:0] RegClass3Bytes = 3'd3;
  localparam logic [CfgIdxW-1:0] RegMaxBlocks   = 3'd4;
  localparam logic [CfgIdxW-1:0] RegGrowQuantum = 3'd5;
  localparam logic [CfgIdxW-1:0] RegInitBlocks  = 3'd6;

  // Per-class counters.
  typedef logic [NumClasses-1:0][CntW-1:0] scba_cnt_arr_t;

  // Configuration as seen by the class selector.
  typedef struct packed {
    logic [NumClasses-1:0][LenW-1:0] class_bytes;
    logic [CntW-1:0]                 max_blocks;
    logic [CntW-1:0]                 grow_quantum;
    logic [CntW-1:0]                 initial_blocks;
  } scba_cfg_t;

  // Class choice for one allocation.
  typedef struct packed {
    logic            hit;
    logic [ClsW-1:0] cls;
    logic            pop;
    logic            run;
    logic            grow;
    logic [CntW-1:0] grow_n;
  } scba_pick_t;

endpackage

FILE: hdl/scba_class_sel.sv
// ----------------------------------------------------------------------------
// scba_class_sel
// Chooses the class and the source of the block for one allocation.
// ----------------------------------------------------------------------------
module scba_class_sel (
  input  scba_pkg::scba_cfg_t     cfg_i,
  input  logic [31:0]             req_len_i,
  input  scba_pkg::scba_cnt_arr_t stack_depth_i,
  input  scba_pkg::scba_cnt_arr_t carved_i,
  input  scba_pkg::scba_cnt_arr_t run_next_i,
  output scba_pkg::scba_pick_t    pick_o
);
  import scba_pkg::*;

  localparam logic [CntW-1:0] MaxBlocksCnt = CntW'(MaxBlocks);

  logic [CntW-1:0]       lim;
  logic [NumClasses-1:0] fits;
  logic [NumClasses-1:0] has_pop;
  logic [NumClasses-1:0] has_run;
  logic [NumClasses-1:0] avail;
  scba_cnt_arr_t         n_init;
  scba_cnt_arr_t         room;
  scba_cnt_arr_t         grow_n;

  // Growth size and availability of every class, side by side.
  always_comb begin
    lim = (cfg_i.max_blocks < MaxBlocksCnt) ? cfg_i.max_blocks : MaxBlocksCnt;
    for (int c = 0; c < NumClasses; c++) begin
      fits[c]    = req_len_i <= cfg_i.class_bytes[c];
      has_pop[c] = stack_depth_i[c] != '0;
      has_run[c] = run_next_i[c] < carved_i[c];
      n_init[c]  = (cfg_i.initial_blocks < lim) ? cfg_i.initial_blocks : lim;
      room[c]    = lim - carved_i[c];
      if (carved_i[c] == '0) begin
        if (n_init[c] != '0) begin
          grow_n[c] = n_init[c];
        end else begin
          grow_n[c] = (lim < cfg_i.grow_quantum) ? lim : cfg_i.grow_quantum;
        end
      end else if (carved_i[c] >= lim) begin
        grow_n[c] = '0;
      end else begin
        grow_n[c] = (room[c] < cfg_i.grow_quantum) ? room[c] : cfg_i.grow_quantum;
      end
      avail[c] = fits[c] && (has_pop[c] || has_run[c] || (grow_n[c] != '0));
    end
  end

  // The lowest available class wins.
  always_comb begin
    pick_o = '0;
    for (int c = NumClasses - 1; c >= 0; c--) begin
      if (avail[c]) begin
        pick_o.hit    = 1'b1;
        pick_o.cls    = ClsW'(c);
        pick_o.pop    = has_pop[c];
        pick_o.run    = !has_pop[c] && has_run[c];
        pick_o.grow   = !has_pop[c] && !has_run[c];
        pick_o.grow_n = grow_n[c];
      end
    end
  end

endmodule

FILE: hdl/size_class_buffer_allocator.sv
// ----------------------------------------------------------------------------
// size_class_buffer_allocator
// Hands out and takes back buffer blocks from four size classes.
// ----------------------------------------------------------------------------
// Requests enter on the s_axis channel: tuser carries the action (allocate
// or free), tdata the length and the handle of a freed block. Every request
// gives exactly one result beat on the m_axis channel with the status in
// tuser and the granted class, index and growth flag in tdata.
// A request is held in the input register, where the class is chosen
// and the counters and free stacks are updated; it then moves to the
// result register, which drives the m_axis channel. One request per
// cycle is sustained while the receiver does not stall; the free stack
// memory is read at the decision edge and its registered data feeds the
// result directly, so a free and a following pop of the same entry go
// back to back.
// Reset empties every free stack and clears the carved counts; stack
// contents are never read before they are written, so no clearing pass
// is run. The user writes configuration through cfg_we_i only while the
// block is idle; the block does not enforce it. When the receiver stalls,
// the result and input registers fill in turn, then s_axis_tready drops.
// ----------------------------------------------------------------------------
module size_class_buffer_allocator (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Configuration write port.
  input  logic                           cfg_we_i,
  input  logic [scba_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [scba_pkg::CfgDataW-1:0]  cfg_wdata_i,
  // Request stream.
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // tdata: request_length[31:0], handle_valid[32], free_class[34:33],
  //        free_index[44:35], zero padding above.
  input  logic [scba_pkg::InDataW-1:0]   s_axis_tdata,
  // tuser: action[0].
  input  logic [0:0]                     s_axis_tuser,
  // Result stream.
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // tdata: block_class[1:0], block_index[11:2], grew[12], zero padding above.
  output logic [scba_pkg::OutDataW-1:0]  m_axis_tdata,
  // tuser: status[1:0].
  output logic [scba_pkg::StW-1:0]       m_axis_tuser
);
  import scba_pkg::*;

  localparam logic [CntW-1:0] MaxBlocksCnt = CntW'(MaxBlocks);

  // Configuration registers.
  scba_cfg_t cfg_q;

  // Per-class state.
  scba_cnt_arr_t stack_depth_q, stack_depth_d;
  scba_cnt_arr_t carved_q, carved_d;
  scba_cnt_arr_t run_next_q, run_next_d;

  // Input register.
  logic             v1_q;
  logic             act_q;
  logic [LenW-1:0]  len_q;
  logic             hv_q;
  logic [ClsW-1:0]  fcls_q;
  logic [IdxW-1:0]  fidx_q;

  // Result register.
  logic             v2_q;
  logic [StW-1:0]   status_q, status_d;
  logic [ClsW-1:0]  cls_q, cls_d;
  logic [IdxW-1:0]  idx_q, idx_d;
  logic             grew_q, grew_d;
  logic             pop_q, pop_d;

  // Free stack memory.
  logic [IdxW-1:0]  stack_mem [NumClasses*MaxBlocks];
  logic [IdxW-1:0]  rdata_q;
  logic             mem_we;
  logic             mem_re;
  logic [AddrW-1:0] mem_waddr;
  logic [AddrW-1:0] mem_raddr;

  logic             s_accept;
  logic             s2_free;
  logic             adv1;
  logic             free_ok;
  scba_pick_t       pick;

  // Handshake and stage advance.
  assign s2_free       = !v2_q || m_axis_tready;
  assign adv1          = v1_q && s2_free;
  assign s_axis_tready = !v1_q || s2_free;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  // Configuration writes; indexes past the list are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.class_bytes[0] <= 32'd16384;
      cfg_q.class_bytes[1] <= 32'd65536;
      cfg_q.class_bytes[2] <= 32'd262144;
      cfg_q.class_bytes[3] <= 32'd1048576;
      cfg_q.max_blocks     <= CntW'(1024);
      cfg_q.grow_quantum   <= CntW'(128);
      cfg_q.initial_blocks <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegClass0Bytes: cfg_q.class_bytes[0] <= cfg_wdata_i;
        RegClass1Bytes: cfg_q.class_bytes[1] <= cfg_wdata_i;
        RegClass2Bytes: cfg_q.class_bytes[2] <= cfg_wdata_i;
        RegClass3Bytes: cfg_q.class_bytes[3] <= cfg_wdata_i;
        RegMaxBlocks:   cfg_q.max_blocks     <= cfg_wdata_i[CntW-1:0];
        RegGrowQuantum: cfg_q.grow_quantum   <= cfg_wdata_i[CntW-1:0];
        RegInitBlocks:  cfg_q.initial_blocks <= cfg_wdata_i[CntW-1:0];
        default: ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (s_accept) begin
      v1_q <= 1'b1;
    end else if (adv1) begin
      v1_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      act_q  <= s_axis_tuser[0];
      len_q  <= s_axis_tdata[31:0];
      hv_q   <= s_axis_tdata[32];
      fcls_q <= s_axis_tdata[34:33];
      fidx_q <= s_axis_tdata[44:35];
    end
  end

  // Class choice for the held request.
  scba_class_sel u_class_sel (
    .cfg_i         (cfg_q),
    .req_len_i     (len_q),
    .stack_depth_i (stack_depth_q),
    .carved_i      (carved_q),
    .run_next_i    (run_next_q),
    .pick_o        (pick)
  );

  assign free_ok = hv_q && (stack_depth_q[fcls_q] < MaxBlocksCnt);

  // Decision: next counters, stack access and result fields.
  always_comb begin
    stack_depth_d = stack_depth_q;
    carved_d      = carved_q;
    run_next_d    = run_next_q;
    status_d      = StFail;
    cls_d         = '0;
    idx_d         = '0;
    grew_d        = 1'b0;
    pop_d         = 1'b0;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    mem_waddr     = {fcls_q, stack_depth_q[fcls_q][IdxW-1:0]};
    mem_raddr     = {pick.cls, stack_depth_q[pick.cls][IdxW-1:0] - IdxW'(1)};
    if (act_q == ActFree) begin
      status_d = StIgnored;
      if (free_ok) begin
        status_d              = StOk;
        mem_we                = adv1;
        stack_depth_d[fcls_q] = stack_depth_q[fcls_q] + CntW'(1);
      end
    end else if (pick.hit) begin
      status_d = StOk;
      cls_d    = pick.cls;
      if (pick.pop) begin
        pop_d                   = 1'b1;
        mem_re                  = adv1;
        stack_depth_d[pick.cls] = stack_depth_q[pick.cls] - CntW'(1);
      end else if (pick.run) begin
        idx_d                = run_next_q[pick.cls][IdxW-1:0];
        run_next_d[pick.cls] = run_next_q[pick.cls] + CntW'(1);
      end else begin
        grew_d               = 1'b1;
        idx_d                = carved_q[pick.cls][IdxW-1:0];
        run_next_d[pick.cls] = carved_q[pick.cls] + CntW'(1);
        carved_d[pick.cls]   = carved_q[pick.cls] + pick.grow_n;
      end
    end
  end

  // Per-class counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stack_depth_q <= '0;
      carved_q      <= '0;
      run_next_q    <= '0;
    end else if (adv1) begin
      stack_depth_q <= stack_depth_d;
      carved_q      <= carved_d;
      run_next_q    <= run_next_d;
    end
  end

  // Free stack memory with registered read.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      stack_mem[mem_waddr] <= fidx_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      rdata_q <= stack_mem[mem_raddr];
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (adv1) begin
      v2_q <= 1'b1;
    end else if (m_axis_tready) begin
      v2_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1) begin
      status_q <= status_d;
      cls_q    <= cls_d;
      idx_q    <= idx_d;
      grew_q   <= grew_d;
      pop_q    <= pop_d;
    end
  end

  // Popped blocks take their index from the memory read register.
  assign m_axis_tvalid = v2_q;
  assign m_axis_tuser  = status_q;
  assign m_axis_tdata  = {(OutDataW - 13)'(0), grew_q, (pop_q ? rdata_q : idx_q), cls_q};

`ifndef NO_ASSERTIONS
  // A popped block is always a successful grant.
  a_pop_is_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v2_q && pop_q) |-> (status_q == StOk && !grew_q))
    else $error("pop result without ok status");

  // No stack ever holds more than a class's worth of blocks.
  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stack_depth_q[0] <= MaxBlocksCnt) && (stack_depth_q[1] <= MaxBlocksCnt) &&
    (stack_depth_q[2] <= MaxBlocksCnt) && (stack_depth_q[3] <= MaxBlocksCnt))
    else $error("free stack depth out of range");

  // The run pointer never passes the carved count.
  a_run_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (run_next_q[0] <= carved_q[0]) && (run_next_q[1] <= carved_q[1]) &&
    (run_next_q[2] <= carved_q[2]) && (run_next_q[3] <= carved_q[3]))
    else $error("run pointer beyond carved blocks");

  // A decided request always lands in the result register.
  a_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv1 |=> v2_q)
    else $error("decided request lost");

  // Input backpressure only while the input register is occupied.
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (v1_q && v2_q && !m_axis_tready))
    else $error("input stalled without cause");
`endif

endmodule
